>>> design/wsd_pkg.sv
// ---------------------------------------------------------------------------
// WebSocket deframer package
// Shared payload types, widths and defaults of the frame deframer.
// ---------------------------------------------------------------------------
package wsd_pkg;

  localparam int unsigned FrameLenW      = 31;
  localparam int unsigned LengthBitsDflt = 31;
  localparam int unsigned QueueDepth     = 2;
  localparam int unsigned QueuePtrW      = $clog2(QueueDepth);
  localparam int unsigned QueueCntW      = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } in_t;

  typedef struct packed {
    logic                 payload_valid;
    logic [7:0]           payload_byte;
    logic [3:0]           frame_opcode;
    logic [FrameLenW-1:0] frame_length;
    logic                 frame_end;
    logic                 status;
  } out_t;

  // request handed from the header parser to the output stage
  typedef struct packed {
    logic                 payload_valid;
    logic [7:0]           data_byte;
    logic [31:0]          mask_key;
    logic [1:0]           mask_lane;
    logic [3:0]           frame_opcode;
    logic [FrameLenW-1:0] frame_length;
    logic                 frame_end;
    logic                 status;
  } req_t;

endpackage

>>> design/wsd_front.sv
// ---------------------------------------------------------------------------
// WebSocket deframer front end
// Accepts received bytes, walks the frame header and classifies each byte,
// pushing one request per result into the queue.
// ---------------------------------------------------------------------------
module wsd_front #(
  parameter int unsigned LENGTH_BITS = wsd_pkg::LengthBitsDflt
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  wsd_pkg::in_t  in_data_i,
  output logic          push_o,
  output wsd_pkg::req_t req_o
);

  typedef enum logic [7:0] {
    PhFirst    = 8'b0000_0001,
    PhSecond   = 8'b0000_0010,
    PhExt16    = 8'b0000_0100,
    PhExt64    = 8'b0000_1000,
    PhMask     = 8'b0001_0000,
    PhPayload  = 8'b0010_0000,
    PhDrop     = 8'b0100_0000,
    PhOversize = 8'b1000_0000
  } phase_e;

  localparam logic [6:0] Len16Code    = 7'd126;
  localparam logic [3:0] Ext16Bytes   = 4'd2;
  localparam logic [3:0] Ext64LowByte = 4'd5;
  localparam logic [3:0] Ext64Bytes   = 4'd8;
  localparam logic [3:0] MaskBytes    = 4'd4;

  phase_e                 phase_q, phase_d;
  logic [3:0]             cnt_q, cnt_d;
  logic [3:0]             opcode_q, opcode_d;
  logic                   mask_q, mask_d;
  logic [31:0]            key_q, key_d;
  logic [LENGTH_BITS-1:0] len_q, len_d;
  logic [LENGTH_BITS-1:0] left_q, left_d;
  logic [1:0]             lane_q, lane_d;

  logic [LENGTH_BITS+7:0] wide;
  logic [7:0]             b;
  logic                   be;
  logic                   trunc, len_done, hdr_done, over_end;
  logic                   res_valid, res_end, res_status;

  assign b    = in_data_i.data_byte;
  assign be   = in_data_i.buffer_end;
  assign wide = {len_q, b};

  always_comb begin
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    opcode_d   = opcode_q;
    mask_d     = mask_q;
    key_d      = key_q;
    len_d      = len_q;
    left_d     = left_q;
    lane_d     = lane_q;
    trunc      = 1'b0;
    len_done   = 1'b0;
    hdr_done   = 1'b0;
    over_end   = 1'b0;
    push_o     = 1'b0;
    res_valid  = 1'b0;
    res_end    = 1'b0;
    res_status = 1'b0;
    if (accept_i) begin
      unique case (phase_q)
        PhFirst: begin
          opcode_d = b[3:0];
          mask_d   = 1'b0;
          key_d    = '0;
          len_d    = '0;
          left_d   = '0;
          lane_d   = '0;
          cnt_d    = '0;
          if (be) trunc = 1'b1;
          else    phase_d = PhSecond;
        end
        PhSecond: begin
          mask_d = b[7];
          cnt_d  = '0;
          if (b[6:0] < Len16Code) begin
            len_d    = LENGTH_BITS'(b[6:0]);
            len_done = 1'b1;
          end else begin
            phase_d = (b[6:0] == Len16Code) ? PhExt16 : PhExt64;
            if (be) trunc = 1'b1;
          end
        end
        PhExt16: begin
          len_d = wide[LENGTH_BITS-1:0];
          cnt_d = cnt_q + 4'd1;
          if (cnt_d >= Ext16Bytes) len_done = 1'b1;
          else if (be)             trunc    = 1'b1;
        end
        PhExt64: begin
          cnt_d = cnt_q + 4'd1;
          if (cnt_d >= Ext64LowByte) begin
            if (wide[LENGTH_BITS+7:LENGTH_BITS] != 8'h00) begin
              len_d   = '0;
              phase_d = PhOversize;
            end else begin
              len_d = wide[LENGTH_BITS-1:0];
            end
          end
          if (cnt_d >= Ext64Bytes) begin
            if (phase_d == PhOversize) over_end = 1'b1;
            else                       len_done = 1'b1;
          end else if (be) begin
            trunc = 1'b1;
          end
        end
        PhOversize: begin
          cnt_d = cnt_q + 4'd1;
          if (cnt_d >= Ext64Bytes) over_end = 1'b1;
          else if (be)             trunc    = 1'b1;
        end
        PhMask: begin
          key_d = {key_q[23:0], b};
          cnt_d = cnt_q + 4'd1;
          if (cnt_d >= MaskBytes) hdr_done = 1'b1;
          else if (be)            trunc    = 1'b1;
        end
        PhPayload: begin
          lane_d = lane_q + 2'd1;
          left_d = left_q - LENGTH_BITS'(1);
          if (left_d == '0) begin
            phase_d   = be ? PhFirst : PhDrop;
            push_o    = 1'b1;
            res_valid = 1'b1;
            res_end   = 1'b1;
          end else if (be) begin
            trunc = 1'b1;
          end else begin
            push_o    = 1'b1;
            res_valid = 1'b1;
          end
        end
        PhDrop: begin
          if (be) phase_d = PhFirst;
        end
        default: phase_d = PhFirst;
      endcase

      if (len_done) begin
        if (mask_d) begin
          phase_d = PhMask;
          cnt_d   = '0;
          if (be) trunc = 1'b1;
        end else begin
          hdr_done = 1'b1;
        end
      end

      if (hdr_done) begin
        if (len_d == '0) begin
          phase_d = be ? PhFirst : PhDrop;
          push_o  = 1'b1;
          res_end = 1'b1;
        end else if (be) begin
          trunc = 1'b1;
        end else begin
          phase_d = PhPayload;
          left_d  = len_d;
          lane_d  = '0;
        end
      end

      if (over_end) begin
        phase_d    = be ? PhFirst : PhDrop;
        push_o     = 1'b1;
        res_end    = 1'b1;
        res_status = 1'b1;
      end

      if (trunc) begin
        phase_d    = PhFirst;
        push_o     = 1'b1;
        res_valid  = 1'b0;
        res_end    = 1'b1;
        res_status = 1'b1;
      end
    end
  end

  always_comb begin
    req_o.payload_valid = res_valid;
    req_o.data_byte     = res_valid ? b : 8'h00;
    req_o.mask_key      = mask_q ? key_q : 32'h0;
    req_o.mask_lane     = lane_q;
    req_o.frame_opcode  = opcode_d;
    req_o.frame_length  = wsd_pkg::FrameLenW'(len_d);
    req_o.frame_end     = res_end;
    req_o.status        = res_status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhFirst;
      cnt_q    <= '0;
      opcode_q <= '0;
      mask_q   <= 1'b0;
      key_q    <= '0;
      len_q    <= '0;
      left_q   <= '0;
      lane_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      opcode_q <= opcode_d;
      mask_q   <= mask_d;
      key_q    <= key_d;
      len_q    <= len_d;
      left_q   <= left_d;
      lane_q   <= lane_d;
    end
  end

endmodule

>>> design/wsd_queue.sv
// ---------------------------------------------------------------------------
// WebSocket deframer request queue
// Small FIFO between the header parser and the output stage.
// ---------------------------------------------------------------------------
module wsd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  wsd_pkg::req_t req_i,
  input  logic          pop_i,
  output wsd_pkg::req_t req_o,
  output logic          full_o,
  output logic          empty_o
);

  localparam int unsigned Depth = wsd_pkg::QueueDepth;
  localparam int unsigned PtrW  = wsd_pkg::QueuePtrW;
  localparam int unsigned CntW  = wsd_pkg::QueueCntW;

  wsd_pkg::req_t   slot_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign req_o   = slot_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    if (do_pop)  rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    if (do_push && !do_pop)      cnt_d = cnt_q + CntW'(1);
    else if (do_pop && !do_push) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_q] <= req_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> design/wsd_back.sv
// ---------------------------------------------------------------------------
// WebSocket deframer back end
// Takes requests from the queue, unmasks payload bytes and holds each result
// in the output register until it is taken.
// ---------------------------------------------------------------------------
module wsd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  wsd_pkg::req_t req_i,
  input  logic          empty_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output wsd_pkg::out_t out_data_o
);

  logic          valid_q;
  wsd_pkg::out_t res_q, res_d;
  logic [7:0]    key_byte;

  assign pop_o       = !empty_i && (!valid_q || out_ready_i);
  assign out_valid_o = valid_q;
  assign out_data_o  = res_q;

  // lane 0 is the first key byte received, held in the top byte
  always_comb begin
    unique case (req_i.mask_lane)
      2'd0: key_byte = req_i.mask_key[31:24];
      2'd1: key_byte = req_i.mask_key[23:16];
      2'd2: key_byte = req_i.mask_key[15:8];
      2'd3: key_byte = req_i.mask_key[7:0];
      default: key_byte = 8'h00;
    endcase
  end

  always_comb begin
    res_d.payload_valid = req_i.payload_valid;
    res_d.payload_byte  = req_i.payload_valid ? (req_i.data_byte ^ key_byte) : 8'h00;
    res_d.frame_opcode  = req_i.frame_opcode;
    res_d.frame_length  = req_i.frame_length;
    res_d.frame_end     = req_i.frame_end;
    res_d.status        = req_i.status;
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

endmodule

>>> design/websocket_frame_deframer.sv
// ---------------------------------------------------------------------------
// WebSocket frame deframer
// Parses frame headers from a received byte stream and emits unmasked
// payload bytes, frame ends and error reports.
// ---------------------------------------------------------------------------
// One received byte is taken per clock cycle while the queue is not full.
// The header parser handles each byte in the cycle it is accepted and queues
// at most one result for it in a two-entry queue; the output stage moves a
// result from the queue into the output register. Input ready falls only
// when the queue is full, that is when the consumer has not taken the result
// in the output register and two more results wait in the queue. A frame
// starts at the first byte of a buffer; payload bytes of a frame that ends in
// a truncation error must be discarded by the consumer.
module websocket_frame_deframer #(
  parameter int unsigned LENGTH_BITS = wsd_pkg::LengthBitsDflt
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  wsd_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output wsd_pkg::out_t out_data_o
);

  logic          accept, push, pop, full, empty;
  wsd_pkg::req_t push_req, head_req;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;

  wsd_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_data_i (in_data_i),
    .push_o    (push),
    .req_o     (push_req)
  );

  wsd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .req_i   (push_req),
    .pop_i   (pop),
    .req_o   (head_req),
    .full_o  (full),
    .empty_o (empty)
  );

  wsd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (head_req),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
